@@ rtl/core/ddq_pkg.sv @@
// Package for the double-ended queue: item and result struct types,
// opcode and status codes, default depth. Depends on nothing.
`default_nettype none

package ddq_pkg;

    localparam int DEFAULT_MAX_ELEMENTS = 32;
    localparam int VALUE_W              = 32;
    localparam int OPCODE_W             = 3;
    localparam int STATUS_W             = 2;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TRAVERSE   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_RESTART    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] item_value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element_value;
        logic [STATUS_W-1:0]       status;
        logic                      last_of_run;
    } result_t;

endpackage : ddq_pkg

`default_nettype wire

@@ rtl/core/double_ended_queue_top.sv @@
// Top level of the double-ended queue: front pointer, count, traverse
// sequencer and result register. Depends on ddq_pkg and ddq_store.
`default_nettype none

// Bounded deque of signed 32-bit values in a ring store of MAX_ELEMENTS
// entries. An item is taken when start is high and busy is low. Every item
// gives its first result in the cycle after it is taken, with result_valid high
// for exactly one cycle per result; the receiver cannot stall, so results
// must be taken as they appear. Push, pop, restart and unused opcodes give
// one result and the next item may be taken in the following cycle.
// Traverse of a list of n elements gives n results back to back and holds
// busy high until the last element has been read, since the store has
// one read port and each element is one read. Traverse of an empty list
// gives one result with status empty. No clearing pass follows reset.
module double_ended_queue_top #(
    parameter int MAX_ELEMENTS = ddq_pkg::DEFAULT_MAX_ELEMENTS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire ddq_pkg::cmd_t    cmd,
    output logic                  result_valid,
    output ddq_pkg::result_t      result
);
    import ddq_pkg::*;

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_ELEMENTS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_ELEMENTS);
    localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(MAX_ELEMENTS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TRAV = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [IW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      trav_ptr_reg, trav_ptr_next;
    logic [CW-1:0]      trav_idx_reg, trav_idx_next;

    logic               res_valid_reg, res_valid_next;
    logic               res_mem_reg, res_mem_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic               res_last_reg, res_last_next;

    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;

    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic [IW-1:0]      front_inc;
    logic [IW-1:0]      front_dec;
    logic [IW-1:0]      trav_ptr_inc;
    logic [CW:0]        back_sum;
    logic [IW-1:0]      back_addr;
    logic [CW-1:0]      trav_idx_inc;

    ddq_store #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.item_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy     = (state_reg == ST_TRAV);
    assign accept   = start && !busy;
    assign is_full  = (count_reg >= FULL_CNT);
    assign is_empty = (count_reg == '0);

    assign front_inc    = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec    = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign trav_ptr_inc = (trav_ptr_reg == LAST_IDX) ? '0 : trav_ptr_reg + 1'b1;
    assign trav_idx_inc = trav_idx_reg + 1'b1;

    // front + count stays below twice the depth: one compare and subtract
    assign back_sum  = {{(CW + 1 - IW){1'b0}}, front_reg} + {1'b0, count_reg};
    assign back_addr = (back_sum >= DEPTH_EXT) ? IW'(back_sum - DEPTH_EXT)
                                               : IW'(back_sum);

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        trav_ptr_next   = trav_ptr_reg;
        trav_idx_next   = trav_idx_reg;
        res_valid_next  = 1'b0;
        res_mem_next    = 1'b0;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        wr_en           = 1'b0;
        wr_addr         = front_reg;
        rd_en           = 1'b0;
        rd_addr         = front_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = STATUS_OK;
                    res_last_next   = 1'b1;
                    case (cmd.opcode)
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                front_next = front_dec;
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = back_addr;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_TRAVERSE:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // read the front now, walk the rest one entry a cycle
                                rd_en         = 1'b1;
                                rd_addr       = front_reg;
                                res_mem_next  = 1'b1;
                                res_last_next = (count_reg == CW'(1));
                                trav_ptr_next = front_inc;
                                trav_idx_next = CW'(1);
                                if (count_reg != CW'(1))
                                begin
                                    state_next = ST_TRAV;
                                end
                            end
                        end
                        OP_RESTART:
                        begin
                            front_next = '0;
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            count_next = CW'(1);
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_TRAV:
            begin
                rd_en           = 1'b1;
                rd_addr         = trav_ptr_reg;
                res_valid_next  = 1'b1;
                res_mem_next    = 1'b1;
                res_status_next = STATUS_OK;
                res_last_next   = (trav_idx_inc == count_reg);
                trav_ptr_next   = trav_ptr_inc;
                trav_idx_next   = trav_idx_inc;
                if (trav_idx_inc == count_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            trav_ptr_reg  <= '0;
            trav_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
            res_mem_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            trav_ptr_reg  <= trav_ptr_next;
            trav_idx_reg  <= trav_idx_next;
            res_valid_reg <= res_valid_next;
            res_mem_reg   <= res_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

    assign result_valid         = res_valid_reg;
    assign result.element_value = res_mem_reg ? rd_data : '0;
    assign result.status        = res_status_reg;
    assign result.last_of_run   = res_last_reg;

endmodule : double_ended_queue_top

`default_nettype wire

@@ rtl/core/ddq_store.sv @@
// Element store of the double-ended queue: one write port, one read port,
// registered read data. Depends on ddq_pkg for the value width.
`default_nettype none

module ddq_store #(
    parameter int DEPTH = ddq_pkg::DEFAULT_MAX_ELEMENTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [ddq_pkg::VALUE_W-1:0]   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [ddq_pkg::VALUE_W-1:0]   rd_data
);
    import ddq_pkg::*;

    logic [VALUE_W-1:0] store_mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : ddq_store

`default_nettype wire
